>>> rtl/rotation_matrix_to_euler_top_assert.svh
// Assertion macros used by the top-level RTL; they expect clk_i and rst_ni in scope.
`ifndef ROTATION_MATRIX_TO_EULER_TOP_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_TOP_ASSERT_SVH

// Check that a condition holds on every clock edge outside reset.
`define RM2E_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its trigger.
`define RM2E_ASSERT_IMPLY(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/rm2e_pkg.sv
`default_nettype none
package rm2e_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 14;
  localparam int unsigned ELEMENT_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH      = 4;

  localparam int unsigned PRESCALE_SHIFT = 20;
  localparam int unsigned ATAN_TAB_LEN   = 30;
  localparam int unsigned ANGLE_W        = 34;

  localparam int unsigned HEADING_W = 16;
  localparam int unsigned PITCH_W   = 15;
  localparam int unsigned ROLL_W    = 16;
  localparam int unsigned THRESH_W  = 15;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic signed [ANGLE_W-1:0] ANGLE_PI_2 = 34'sd1686629713;
  localparam logic signed [ANGLE_W-1:0] ANGLE_RND  = 34'sd65536;
  localparam int unsigned               ANGLE_OUT_SHIFT = 17;

  localparam logic signed [HEADING_W-1:0] OUT_PI   = 16'sd25736;
  localparam logic signed [PITCH_W-1:0]   OUT_PI_2 = 15'sd12868;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd16368;

  // round(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_TAB [ATAN_TAB_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

  typedef enum logic [0:0] {
    REG_LOCK_THRESHOLD = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    PITCH_CORDIC    = 2'b00,
    PITCH_POS_CLAMP = 2'b01,
    PITCH_NEG_CLAMP = 2'b10
  } pitch_mode_e;

  // Bits of one classified item passed from front to back.
  function automatic int unsigned item_width(input int unsigned eb);
    return 6 * eb + 7;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rm2e_if.sv
`default_nettype none
interface rm2e_in_if #(
  parameter int unsigned EW = 16
);
  logic          valid;
  logic          ready;
  logic signed [EW-1:0] m_zy;
  logic signed [EW-1:0] m_xx;
  logic signed [EW-1:0] m_zx;
  logic signed [EW-1:0] m_zz;
  logic signed [EW-1:0] m_xy;
  logic signed [EW-1:0] m_yy;

  modport source (output valid, m_zy, m_xx, m_zx, m_zz, m_xy, m_yy, input ready);
  modport sink   (input valid, m_zy, m_xx, m_zx, m_zz, m_xy, m_yy, output ready);
endinterface

interface rm2e_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading;
  logic signed [14:0] pitch;
  logic signed [15:0] roll;
  logic               gimbal_locked;

  modport source (output valid, heading, pitch, roll, gimbal_locked, input ready);
  modport sink   (input valid, heading, pitch, roll, gimbal_locked, output ready);
endinterface
`default_nettype wire

>>> rtl/rm2e_front.sv
`default_nettype none
module rm2e_front #(
  parameter int unsigned ELEMENT_BITS = rm2e_pkg::ELEMENT_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [rm2e_pkg::THRESH_W-1:0]          thresh_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [ELEMENT_BITS-1:0]         m_zy_i,
  input  logic signed [ELEMENT_BITS-1:0]         m_xx_i,
  input  logic signed [ELEMENT_BITS-1:0]         m_zx_i,
  input  logic signed [ELEMENT_BITS-1:0]         m_zz_i,
  input  logic signed [ELEMENT_BITS-1:0]         m_xy_i,
  input  logic signed [ELEMENT_BITS-1:0]         m_yy_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [rm2e_pkg::item_width(ELEMENT_BITS)-1:0] out_item_o
);
  import rm2e_pkg::*;

  localparam int unsigned EW    = ELEMENT_BITS + 1;
  localparam int unsigned H     = ELEMENT_BITS - 2;
  localparam int unsigned NW    = 2 * H + 2;
  localparam int unsigned RW    = H + 4;
  localparam int unsigned SQ    = H + 1;
  localparam int unsigned FL    = SQ + 2;
  localparam int unsigned CMP_W = (EW > 16) ? EW : 16;

  localparam logic signed [EW-1:0] ONE    = {{(EW-H-1){1'b0}}, 1'b1, {H{1'b0}}};
  localparam logic [NW-1:0]        ONE_SQ = {2'b01, {(2*H){1'b0}}};

  typedef struct packed {
    logic signed [EW-1:0] hy;
    logic signed [EW-1:0] hx;
    logic signed [EW-1:0] ry;
    logic signed [EW-1:0] rx;
    logic signed [EW-1:0] sinp;
    pitch_mode_e          pmode;
    logic                 locked;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [H:0]  c;
  } item_t;

  logic              en;
  logic [FL-1:0]     v_q;
  side_t             side_q [FL];
  side_t             side_d;
  logic [H-1:0]      a_q;
  logic [H-1:0]      a_d;
  logic [2*H-1:0]    sq_w;
  logic [NW-1:0]     n_q;
  logic [RW-1:0]     rem_q  [SQ];
  logic [SQ-1:0]     root_q [SQ];
  logic [NW-1:0]     nsh_q  [SQ];

  logic signed [EW-1:0]    sinp_w;
  logic signed [EW-1:0]    abs_w;
  logic signed [CMP_W-1:0] sinp_c;
  logic signed [CMP_W-1:0] thr_c;
  item_t                   item_w;

  assign en         = !v_q[FL-1] || out_ready_i;
  assign in_ready_o = en;

  // Classify the incoming matrix and pick the atan2 operands.
  always_comb begin
    sinp_w = -EW'(m_zy_i);
    abs_w  = (sinp_w < 0) ? -sinp_w : sinp_w;
    a_d    = abs_w[H-1:0];
    sinp_c = CMP_W'(sinp_w);
    thr_c  = CMP_W'($signed({1'b0, thresh_i}));
    side_d.sinp   = sinp_w;
    side_d.locked = sinp_c > thr_c;
    if (sinp_w <= -ONE) begin
      side_d.pmode = PITCH_NEG_CLAMP;
    end else if (sinp_w >= ONE) begin
      side_d.pmode = PITCH_POS_CLAMP;
    end else begin
      side_d.pmode = PITCH_CORDIC;
    end
    if (side_d.locked) begin
      side_d.hy = sinp_w;
      side_d.hx = EW'(m_xx_i);
    end else begin
      side_d.hy = EW'(m_zx_i);
      side_d.hx = EW'(m_zz_i);
    end
    side_d.ry = EW'(m_xy_i);
    side_d.rx = EW'(m_yy_i);
  end

  assign sq_w = a_q * a_q;

  // Advance the valid line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[FL-2:0], in_valid_i};
    end
  end

  // Advance the sideband and the cosine operand.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < FL; i++) begin
        side_q[i] <= side_q[i-1];
      end
      a_q <= a_d;
      n_q <= ONE_SQ - {2'b00, sq_w};
    end
  end

  // Square root of one^2 - s^2, one result bit per stage.
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [RW-1:0] rem_in;
    logic [SQ-1:0] root_in;
    logic [NW-1:0] nsh_in;
    logic [RW-1:0] rem_s;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_o;
    logic [SQ-1:0] root_o;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign nsh_in  = n_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign nsh_in  = nsh_q[k-1];
    end

    always_comb begin
      rem_s = {rem_in[RW-3:0], nsh_in[NW-1 -: 2]};
      trial = RW'({root_in, 2'b01});
      if (rem_s >= trial) begin
        rem_o  = rem_s - trial;
        root_o = {root_in[SQ-2:0], 1'b1};
      end else begin
        rem_o  = rem_s;
        root_o = {root_in[SQ-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k]  <= rem_o;
        root_q[k] <= root_o;
        nsh_q[k]  <= {nsh_in[NW-3:0], 2'b00};
      end
    end
  end

  assign item_w.side = side_q[FL-1];
  assign item_w.c    = root_q[SQ-1];
  assign out_valid_o = v_q[FL-1];
  assign out_item_o  = item_w;

endmodule
`default_nettype wire

>>> rtl/rm2e_queue.sv
`default_nettype none
module rm2e_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = rm2e_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q;
  logic [AW-1:0] rd_q;
  logic [AW:0]   cnt_q;
  logic          push;
  logic          pop;

  assign in_ready_o  = cnt_q != (AW+1)'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  // Track pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store the beat.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rm2e_cordic.sv
`default_nettype none
module rm2e_cordic #(
  parameter int unsigned IN_W  = 17,
  parameter int unsigned STEPS = rm2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic signed [IN_W-1:0]                   y_i,
  input  logic signed [IN_W-1:0]                   x_i,
  output logic signed [rm2e_pkg::HEADING_W-1:0]    angle_o
);
  import rm2e_pkg::*;

  localparam int unsigned CW = IN_W + PRESCALE_SHIFT + 2;

  logic signed [CW-1:0]      x_q    [STEPS+1];
  logic signed [CW-1:0]      y_q    [STEPS+1];
  logic signed [ANGLE_W-1:0] z_q    [STEPS+1];
  logic                      zero_q [STEPS+1];

  logic signed [CW-1:0]      xe_w;
  logic signed [CW-1:0]      ye_w;
  logic signed [CW-1:0]      xs_w;
  logic signed [CW-1:0]      ys_w;
  logic signed [CW-1:0]      x0_d;
  logic signed [CW-1:0]      y0_d;
  logic signed [ANGLE_W-1:0] z0_d;
  logic signed [ANGLE_W-1:0] zr_w;
  logic signed [ANGLE_W-1:0] r_w;
  logic signed [HEADING_W-1:0] angle_d;
  logic signed [HEADING_W-1:0] angle_q;

  // Scale up and fold the left half plane by a quarter turn.
  always_comb begin
    xe_w = CW'(x_i);
    ye_w = CW'(y_i);
    xs_w = xe_w <<< PRESCALE_SHIFT;
    ys_w = ye_w <<< PRESCALE_SHIFT;
    if (xs_w < 0) begin
      if (ys_w >= 0) begin
        x0_d = ys_w;
        y0_d = -xs_w;
        z0_d = ANGLE_PI_2;
      end else begin
        x0_d = -ys_w;
        y0_d = xs_w;
        z0_d = -ANGLE_PI_2;
      end
    end else begin
      x0_d = xs_w;
      y0_d = ys_w;
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      z_q[0]    <= z0_d;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [ANGLE_W-1:0] TAB = $signed({2'b00, ATAN_TAB[i]});
    logic signed [CW-1:0]      nx;
    logic signed [CW-1:0]      ny;
    logic signed [ANGLE_W-1:0] nz;

    always_comb begin
      if (y_q[i] > 0) begin
        nx = x_q[i] + (y_q[i] >>> i);
        ny = y_q[i] - (x_q[i] >>> i);
        nz = z_q[i] + TAB;
      end else begin
        nx = x_q[i] - (y_q[i] >>> i);
        ny = y_q[i] + (x_q[i] >>> i);
        nz = z_q[i] - TAB;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= nx;
        y_q[i+1]    <= ny;
        z_q[i+1]    <= nz;
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  // Round to Q3.13, saturate to plus or minus pi, and give zero for a zero vector.
  always_comb begin
    zr_w = z_q[STEPS] + ANGLE_RND;
    r_w  = zr_w >>> ANGLE_OUT_SHIFT;
    if (zero_q[STEPS]) begin
      angle_d = '0;
    end else if (r_w > ANGLE_W'(OUT_PI)) begin
      angle_d = OUT_PI;
    end else if (r_w < -ANGLE_W'(OUT_PI)) begin
      angle_d = -OUT_PI;
    end else begin
      angle_d = r_w[HEADING_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule
`default_nettype wire

>>> rtl/rm2e_back.sv
`default_nettype none
module rm2e_back #(
  parameter int unsigned ELEMENT_BITS = rm2e_pkg::ELEMENT_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = rm2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic [rm2e_pkg::item_width(ELEMENT_BITS)-1:0] in_item_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic signed [rm2e_pkg::HEADING_W-1:0]         heading_o,
  output logic signed [rm2e_pkg::PITCH_W-1:0]           pitch_o,
  output logic signed [rm2e_pkg::ROLL_W-1:0]            roll_o,
  output logic                                          gimbal_locked_o
);
  import rm2e_pkg::*;

  localparam int unsigned EW = ELEMENT_BITS + 1;
  localparam int unsigned H  = ELEMENT_BITS - 2;
  localparam int unsigned L  = CORDIC_STEPS + 2;

  typedef struct packed {
    logic signed [EW-1:0] hy;
    logic signed [EW-1:0] hx;
    logic signed [EW-1:0] ry;
    logic signed [EW-1:0] rx;
    logic signed [EW-1:0] sinp;
    pitch_mode_e          pmode;
    logic                 locked;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [H:0]  c;
  } item_t;

  item_t                       it;
  logic                        en;
  logic [L-1:0]                v_q;
  pitch_mode_e                 mode_q [L];
  logic [L-1:0]                lock_q;
  logic signed [EW-1:0]        cx_w;
  logic signed [HEADING_W-1:0] h_ang;
  logic signed [HEADING_W-1:0] r_ang;
  logic signed [HEADING_W-1:0] p_ang;

  assign it         = item_t'(in_item_i);
  assign en         = !v_q[L-1] || out_ready_i;
  assign in_ready_o = en;
  assign cx_w       = EW'($signed({1'b0, it.c}));

  rm2e_cordic #(.IN_W(EW), .STEPS(CORDIC_STEPS)) u_heading (
    .clk_i(clk_i), .en_i(en), .y_i(it.side.hy), .x_i(it.side.hx), .angle_o(h_ang)
  );

  rm2e_cordic #(.IN_W(EW), .STEPS(CORDIC_STEPS)) u_roll (
    .clk_i(clk_i), .en_i(en), .y_i(it.side.ry), .x_i(it.side.rx), .angle_o(r_ang)
  );

  rm2e_cordic #(.IN_W(EW), .STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i(clk_i), .en_i(en), .y_i(it.side.sinp), .x_i(cx_w), .angle_o(p_ang)
  );

  // Advance the valid line alongside the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[L-2:0], in_valid_i};
    end
  end

  // Carry the pitch mode and lock flag.
  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_q[0] <= it.side.pmode;
      lock_q    <= {lock_q[L-2:0], it.side.locked};
      for (int i = 1; i < L; i++) begin
        mode_q[i] <= mode_q[i-1];
      end
    end
  end

  // Clamp pitch, drop roll under lock.
  always_comb begin
    case (mode_q[L-1])
      PITCH_POS_CLAMP: pitch_o = OUT_PI_2;
      PITCH_NEG_CLAMP: pitch_o = -OUT_PI_2;
      default: begin
        if (p_ang > HEADING_W'(OUT_PI_2)) begin
          pitch_o = OUT_PI_2;
        end else if (p_ang < -HEADING_W'(OUT_PI_2)) begin
          pitch_o = -OUT_PI_2;
        end else begin
          pitch_o = p_ang[PITCH_W-1:0];
        end
      end
    endcase
  end

  assign heading_o       = h_ang;
  assign roll_o          = lock_q[L-1] ? '0 : r_ang;
  assign gimbal_locked_o = lock_q[L-1];
  assign out_valid_o     = v_q[L-1];

endmodule
`default_nettype wire

>>> rtl/rotation_matrix_to_euler_top.sv
// Channel  | Dir | Beat contents
// in_i     | in  | m_zy, m_xx, m_zx, m_zz, m_xy, m_yy (signed Q2.14)
// out_o    | out | heading, roll (signed Q3.13), pitch (signed Q2.13), gimbal_locked
// apb      | in  | lock_threshold at byte address 0
//
// One matrix is taken per cycle unless the front stalls on a full queue. A beat
// passes through the front (classify, square, root), the queue and the CORDIC
// lanes in that order. The queue of four beats lets the front keep taking
// matrices while out_o stalls, until the queue is full.
// Reset is asynchronous, active low; the threshold returns to 16368.
`default_nettype none
module rotation_matrix_to_euler_top #(
  parameter int unsigned CORDIC_STEPS = rm2e_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned ELEMENT_BITS = rm2e_pkg::ELEMENT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  rm2e_in_if.sink                             in_i,
  rm2e_out_if.source                          out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rm2e_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rm2e_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rm2e_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import rm2e_pkg::*;
  `include "rotation_matrix_to_euler_top_assert.svh"

  localparam int unsigned IW = item_width(ELEMENT_BITS);

  logic [THRESH_W-1:0] thresh_q;
  reg_idx_e            reg_idx;
  logic                f_valid;
  logic                f_ready;
  logic [IW-1:0]       f_item;
  logic                b_valid;
  logic                b_ready;
  logic [IW-1:0]       b_item;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  // Hold the lock threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_LOCK_THRESHOLD)) begin
      thresh_q <= pwdata[THRESH_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOCK_THRESHOLD: prdata = APB_DATA_W'(thresh_q);
      default:            prdata = '0;
    endcase
  end

  rm2e_front #(.ELEMENT_BITS(ELEMENT_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thresh_i    (thresh_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .m_zy_i      (in_i.m_zy),
    .m_xx_i      (in_i.m_xx),
    .m_zx_i      (in_i.m_zx),
    .m_zz_i      (in_i.m_zz),
    .m_xy_i      (in_i.m_xy),
    .m_yy_i      (in_i.m_yy),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  rm2e_queue #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_item),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (b_item)
  );

  rm2e_back #(.ELEMENT_BITS(ELEMENT_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (b_valid),
    .in_ready_o      (b_ready),
    .in_item_i       (b_item),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .heading_o       (out_o.heading),
    .pitch_o         (out_o.pitch),
    .roll_o          (out_o.roll),
    .gimbal_locked_o (out_o.gimbal_locked)
  );

  `RM2E_ASSERT_IMPLY(a_roll_zero_locked, out_o.valid && out_o.gimbal_locked, out_o.roll == '0, "roll not zero under gimbal lock")
  `RM2E_ASSERT_IMPLY(a_pitch_range, out_o.valid, (out_o.pitch <= OUT_PI_2) && (out_o.pitch >= -OUT_PI_2), "pitch beyond quarter turn")
  `RM2E_ASSERT_IMPLY(a_heading_range, out_o.valid, (out_o.heading <= OUT_PI) && (out_o.heading >= -OUT_PI), "heading beyond half turn")

endmodule
`default_nettype wire
